>>> sv/image_frame_receiver_defines.svh
// Assertion macros shared by the image frame receiver RTL.
`ifndef IMAGE_FRAME_RECEIVER_DEFINES_SVH
`define IMAGE_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define IFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("image_frame_receiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define IFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("image_frame_receiver: next-cycle check failed");

`endif

>>> sv/ifr_pkg.sv
// Types and constants for the image frame receiver.
package ifr_pkg;

    // Header layout and limits
    localparam int HEADER_BYTES    = 12;
    localparam int MAGIC_BYTES     = 4;
    localparam int MAX_IMAGE_LIMIT = 1024 * 1024;
    localparam int CFG_W           = 21;
    localparam int LEN_W           = 21;
    localparam int HDR_CNT_W       = 4;

    localparam logic [31:0]          FRAME_MAGIC     = 32'hCAFE_BEEF;
    localparam logic [CFG_W-1:0]     MAX_IMAGE_RESET = CFG_W'(MAX_IMAGE_LIMIT);
    localparam logic [CFG_W-1:0]     IMAGE_LIMIT     = CFG_W'(MAX_IMAGE_LIMIT);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX    = HDR_CNT_W'(HEADER_BYTES - 1);
    localparam logic [HDR_CNT_W-1:0] HDR_MAGIC_CNT   = HDR_CNT_W'(MAGIC_BYTES);

    // Input word opcodes
    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } t_opcode;

    // Receiver phase
    typedef enum logic [1:0] {
        PH_SEEK    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SKIP    = 2'd2
    } t_phase;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ABORT   = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    // Header reject causes
    typedef enum logic [1:0] {
        CAUSE_SHORT  = 2'd0,
        CAUSE_MAGIC  = 2'd1,
        CAUSE_LENGTH = 2'd2
    } t_cause;

    // One result word
    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_value;
        logic       last_of_image;
        logic       checksum_good;
        t_cause     reject_cause;
    } t_result;

endpackage

>>> sv/ifr_parser.sv
// Header collection, header checks and payload tracking for the frame receiver.
module ifr_parser import ifr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_fire,
    input  logic             i_opcode,
    input  logic [7:0]       i_data_byte,
    input  logic             i_chunk_last,
    output t_result          o_res,
    output logic             o_res_valid
);

    // State
    logic [CFG_W-1:0]     r_max_bytes, n_max_bytes;
    t_phase               r_phase, n_phase;
    logic [HDR_CNT_W-1:0] r_hdr_count, n_hdr_count;
    logic [31:0]          r_magic, n_magic;
    logic [63:0]          r_hdr_shift, n_hdr_shift;
    logic [LEN_W-1:0]     r_img_len, n_img_len;
    logic [31:0]          r_exp_sum, n_exp_sum;
    logic [LEN_W-1:0]     r_pay_count, n_pay_count;
    logic [7:0]           r_xor, n_xor;

    // Shared datapath terms
    logic                 is_timeout;
    logic [63:0]          hdr_shift_nx;
    logic [31:0]          magic_nx;
    logic                 hdr_done;
    logic [31:0]          len_word;
    logic [CFG_W-1:0]     limit;
    logic                 magic_bad;
    logic                 len_bad;
    logic [LEN_W-1:0]     pay_count_nx;
    logic [7:0]           xor_nx;
    logic                 pay_last;
    logic                 sum_good;

    assign is_timeout   = (t_opcode'(i_opcode) == OP_TIMEOUT);
    assign hdr_shift_nx = {i_data_byte, r_hdr_shift[63:8]};
    assign magic_nx     = {i_data_byte, r_magic[31:8]};
    assign hdr_done     = (r_hdr_count == HDR_LAST_IDX);
    assign len_word     = hdr_shift_nx[31:0];
    assign limit        = (r_max_bytes > IMAGE_LIMIT) ? IMAGE_LIMIT : r_max_bytes;
    assign magic_bad    = (r_magic != FRAME_MAGIC);
    assign len_bad      = (len_word == 32'd0) || (len_word > 32'(limit));
    assign pay_count_nx = r_pay_count + LEN_W'(1);
    assign xor_nx       = r_xor ^ i_data_byte;
    assign pay_last     = (pay_count_nx >= r_img_len);
    assign sum_good     = ({24'd0, xor_nx} == r_exp_sum);

    // Next state
    always_comb begin
        n_max_bytes = r_max_bytes;
        n_phase     = r_phase;
        n_hdr_count = r_hdr_count;
        n_magic     = r_magic;
        n_hdr_shift = r_hdr_shift;
        n_img_len   = r_img_len;
        n_exp_sum   = r_exp_sum;
        n_pay_count = r_pay_count;
        n_xor       = r_xor;

        if (i_cfg_valid) begin
            n_max_bytes = i_cfg_data;
        end

        if (i_fire) begin
            if (is_timeout) begin
                n_phase     = PH_SEEK;
                n_hdr_count = '0;
            end else begin
                case (r_phase)
                    PH_SEEK: begin
                        if (r_hdr_count < HDR_MAGIC_CNT) begin
                            n_magic = magic_nx;
                        end else begin
                            n_hdr_shift = hdr_shift_nx;
                        end
                        if (hdr_done) begin
                            n_hdr_count = '0;
                            if (magic_bad || len_bad) begin
                                n_phase = i_chunk_last ? PH_SEEK : PH_SKIP;
                            end else begin
                                n_img_len   = len_word[LEN_W-1:0];
                                n_exp_sum   = hdr_shift_nx[63:32];
                                n_pay_count = '0;
                                n_xor       = '0;
                                n_phase     = PH_PAYLOAD;
                            end
                        end else if (i_chunk_last) begin
                            n_hdr_count = '0;
                        end else begin
                            n_hdr_count = r_hdr_count + HDR_CNT_W'(1);
                        end
                    end
                    PH_PAYLOAD: begin
                        n_xor       = xor_nx;
                        n_pay_count = pay_count_nx;
                        if (pay_last) begin
                            n_phase = i_chunk_last ? PH_SEEK : PH_SKIP;
                        end
                    end
                    default: begin
                        // skipping the rest of a chunk
                        if (i_chunk_last) begin
                            n_phase     = PH_SEEK;
                            n_hdr_count = '0;
                        end
                    end
                endcase
            end
        end
    end

    // Result word
    always_comb begin
        o_res       = '{kind: KIND_PAYLOAD, byte_value: 8'd0, last_of_image: 1'b0,
                        checksum_good: 1'b0, reject_cause: CAUSE_SHORT};
        o_res_valid = 1'b0;

        if (i_fire) begin
            if (is_timeout) begin
                o_res_valid = (r_phase == PH_PAYLOAD);
                o_res.kind  = KIND_ABORT;
            end else begin
                case (r_phase)
                    PH_SEEK: begin
                        if (hdr_done) begin
                            if (magic_bad) begin
                                o_res_valid        = 1'b1;
                                o_res.kind         = KIND_REJECT;
                                o_res.reject_cause = CAUSE_MAGIC;
                            end else if (len_bad) begin
                                o_res_valid        = 1'b1;
                                o_res.kind         = KIND_REJECT;
                                o_res.reject_cause = CAUSE_LENGTH;
                            end
                        end else if (i_chunk_last) begin
                            o_res_valid        = 1'b1;
                            o_res.kind         = KIND_REJECT;
                            o_res.reject_cause = CAUSE_SHORT;
                        end
                    end
                    PH_PAYLOAD: begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_PAYLOAD;
                        o_res.byte_value    = i_data_byte;
                        o_res.last_of_image = pay_last;
                        o_res.checksum_good = pay_last && sum_good;
                    end
                    default: begin
                        o_res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_IMAGE_RESET;
            r_phase     <= PH_SEEK;
            r_hdr_count <= '0;
        end else begin
            r_max_bytes <= n_max_bytes;
            r_phase     <= n_phase;
            r_hdr_count <= n_hdr_count;
        end
    end

    // Header and payload data registers
    always_ff @(posedge i_clk) begin
        r_magic     <= n_magic;
        r_hdr_shift <= n_hdr_shift;
        r_img_len   <= n_img_len;
        r_exp_sum   <= n_exp_sum;
        r_pay_count <= n_pay_count;
        r_xor       <= n_xor;
    end

endmodule

>>> sv/ifr_out_stage.sv
// Output register for result words, with stall back-pressure.
module ifr_out_stage import ifr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_full_stall
);

    logic    r_valid, n_valid;
    t_result r_res, n_res;

    // Upstream must wait only while a word is held and the receiver stalls
    assign o_full_stall = r_valid && i_stall;

    // Next value of the output register
    always_comb begin
        n_res = r_res;
        if (i_load) begin
            n_valid = 1'b1;
            n_res   = i_res;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> sv/image_frame_receiver.sv
// Image frame receiver: top level.
//
// Input channel (i_valid / o_stall): one word per byte from the link, or a
// receive-timeout event, each byte marked with the end of its transfer chunk.
// Output channel (o_valid / i_stall): payload bytes, timeout aborts and header
// rejects, at most one result word per input word.
// Configuration (i_cfg_valid / o_cfg_ready): the largest accepted payload
// length; ready is always high, write it only while the block is idle.
// A result word is registered and appears on the output in the cycle after
// the input word that causes it is taken.
// Throughput: one input word per cycle while o_stall is low; the header
// checks, payload count and running XOR all settle between the state
// registers and the output register.
// Reset (synchronous, active low) returns to header search, clears the
// output register and restores the length limit to 1 MiB.
// While the receiver stalls with a word held, o_stall is raised and the
// held word stays put; an input word is still taken in the cycle the held
// word leaves.
module image_frame_receiver import ifr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_opcode,
    input  logic [7:0]       i_data_byte,
    input  logic             i_chunk_last,
    // output channel
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte_value,
    output logic             o_last_of_image,
    output logic             o_checksum_good,
    output logic [1:0]       o_reject_cause,
    // configuration
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

`include "image_frame_receiver_defines.svh"

    logic    fire;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    full_stall;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full_stall;
    assign fire        = i_valid && !full_stall;

    // Parser: header, checks and payload
    ifr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_fire       (fire),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .i_chunk_last (i_chunk_last),
        .o_res        (res),
        .o_res_valid  (res_valid)
    );

    // Result register
    ifr_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (res_valid),
        .i_res        (res),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_res        (out_res),
        .o_full_stall (full_stall)
    );

    assign o_kind          = out_res.kind;
    assign o_byte_value    = out_res.byte_value;
    assign o_last_of_image = out_res.last_of_image;
    assign o_checksum_good = out_res.checksum_good;
    assign o_reject_cause  = out_res.reject_cause;

    // Checks
    `IFR_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid)
    `IFR_ASSERT_NOW(a_good_only_on_last, i_clk, i_rst_n, o_valid && o_checksum_good, o_last_of_image)
    `IFR_ASSERT_NOW(a_last_is_payload, i_clk, i_rst_n, o_valid && o_last_of_image, o_kind == KIND_PAYLOAD)
    `IFR_ASSERT_NEXT(a_result_follows_word, i_clk, i_rst_n, !o_valid && !(i_valid && !o_stall), !o_valid)

endmodule
